// ===== hw/rtl/cau_pkg.sv =====
// Shared types, codes and helpers for the complex arithmetic unit.
// No dependencies.
`default_nettype none

package cau_pkg;

    // Operation codes
    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cau_cmd_t;

    // Results of non-divide operations, carried alongside the divider
    typedef struct packed {
        cau_cmd_t    cmd;
        logic [15:0] re;
        logic [15:0] im;
        logic        ovf;
        logic        dz;
    } cau_side_t;

    // Saturate to 16 bits; msb of the result is the saturation flag
    function automatic logic [16:0] sat16(input logic signed [33:0] v);
        logic [16:0] r;
        if (v > 34'sd32767) begin
            r = {1'b1, 16'h7fff};
        end else if (v < -34'sd32768) begin
            r = {1'b1, 16'h8000};
        end else begin
            r = {1'b0, v[15:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cau_div.sv =====
// Pipelined signed floor divider with 16-bit saturation, one quotient bit per stage.
// Depends on cau_pkg.
`default_nettype none

module cau_div #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_vld,
    input  wire logic signed [32:0]    num,
    input  wire logic [31:0]           mag,
    input  wire cau_pkg::cau_side_t    side_in,
    output logic                       out_vld,
    output logic [15:0]                quo,
    output logic                       sat,
    output cau_pkg::cau_side_t         side_out
);
    import cau_pkg::*;

    localparam int NW = 33 + FRAC_BITS;
    localparam int QB = 17;
    localparam int RW = NW + QB;

    logic [RW-1:0] rem_reg  [0:QB];
    logic [QB-1:0] q_reg    [0:QB];
    logic [31:0]   d_reg    [0:QB];
    logic          neg_reg  [0:QB];
    logic          sat_reg  [0:QB];
    logic          vld_reg  [0:QB];
    cau_side_t     side_reg [0:QB];

    // Setup stage: magnitude of the scaled numerator and early overflow test
    logic [32:0]   abs_n;
    logic [RW-1:0] n_scaled;
    assign abs_n    = num[32] ? 33'(-num) : 33'(num);
    assign n_scaled = RW'(abs_n) << FRAC_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= n_scaled;
            q_reg[0]    <= '0;
            d_reg[0]    <= mag;
            neg_reg[0]  <= num[32];
            sat_reg[0]  <= (n_scaled >= (RW'(mag) << QB));
            side_reg[0] <= side_in;
        end
    end

    // Restoring iterations, most significant quotient bit first
    for (genvar k = 1; k <= QB; k++)
    begin : g_iter
        logic [RW-1:0] dsh;
        logic          take;
        assign dsh  = RW'(d_reg[k-1]) << (QB - k);
        assign take = (rem_reg[k-1] >= dsh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= take ? (rem_reg[k-1] - dsh) : rem_reg[k-1];
                q_reg[k]    <= q_reg[k-1] | (take ? (QB'(1) << (QB - k)) : '0);
                d_reg[k]    <= d_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                sat_reg[k]  <= sat_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Final stage: apply sign with floor rounding, then saturate
    logic [QB:0]  q_up;
    logic [15:0]  quo_next;
    logic         sat_next;
    logic [15:0]  quo_reg;
    logic         sat_out_reg;
    logic         vld_out_reg;
    cau_side_t    side_out_reg;

    assign q_up = {1'b0, q_reg[QB]} + (QB+1)'(rem_reg[QB] != '0);

    always_comb
    begin
        if (neg_reg[QB])
        begin
            if (sat_reg[QB] || (q_up > (QB+1)'(32768)))
            begin
                quo_next = 16'h8000;
                sat_next = 1'b1;
            end
            else
            begin
                quo_next = 16'(-q_up);
                sat_next = 1'b0;
            end
        end
        else
        begin
            if (sat_reg[QB] || (q_reg[QB] > QB'(32767)))
            begin
                quo_next = 16'h7fff;
                sat_next = 1'b1;
            end
            else
            begin
                quo_next = q_reg[QB][15:0];
                sat_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_out_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_out_reg <= vld_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg      <= quo_next;
            sat_out_reg  <= sat_next;
            side_out_reg <= side_reg[QB];
        end
    end

    assign out_vld  = vld_out_reg;
    assign quo      = quo_reg;
    assign sat      = sat_out_reg;
    assign side_out = side_out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// Every command takes the same path from input item to result item: stages 1 to 3, then both dividers.
// Throughput: one item per cycle while no result waits; the divider sets most of the depth.
// The whole pipeline advances together and freezes while a result waits.
// Reset clears all valid bits; the data registers are not reset.
// Depends on cau_pkg and cau_div.
`default_nettype none

module complex_arithmetic_unit #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         command,
    input  wire logic signed [15:0] a_real,
    input  wire logic signed [15:0] a_imag,
    input  wire logic signed [15:0] b_real,
    input  wire logic signed [15:0] b_imag,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      res_real,
    output logic signed [15:0]      res_imag,
    output logic                    overflow,
    output logic                    divide_by_zero
);
    import cau_pkg::*;

    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // Stage 1: operand registers
    logic               v1_reg;
    cau_cmd_t           cmd1_reg;
    logic signed [15:0] ar_reg, ai_reg, br_reg, bi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd1_reg <= cau_cmd_t'(command);
            ar_reg   <= a_real;
            ai_reg   <= a_imag;
            br_reg   <= b_real;
            bi_reg   <= b_imag;
        end
    end

    // Stage 2: six products and the add/subtract sums
    logic               v2_reg;
    cau_cmd_t           cmd2_reg;
    logic signed [31:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bb_reg, p_cc_reg;
    logic signed [16:0] as_re_reg, as_im_reg;
    logic signed [16:0] as_re_next, as_im_next;

    always_comb
    begin
        if (cmd1_reg == CMD_SUB)
        begin
            as_re_next = 17'(ar_reg) - 17'(br_reg);
            as_im_next = 17'(ai_reg) - 17'(bi_reg);
        end
        else
        begin
            as_re_next = 17'(ar_reg) + 17'(br_reg);
            as_im_next = 17'(ai_reg) + 17'(bi_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd2_reg  <= cmd1_reg;
            p_rr_reg  <= ar_reg * br_reg;
            p_ii_reg  <= ai_reg * bi_reg;
            p_ri_reg  <= ar_reg * bi_reg;
            p_ir_reg  <= ai_reg * br_reg;
            p_bb_reg  <= br_reg * br_reg;
            p_cc_reg  <= bi_reg * bi_reg;
            as_re_reg <= as_re_next;
            as_im_reg <= as_im_next;
        end
    end

    // Stage 3: product sums, saturation of non-divide results, divider operands
    logic               v3_reg;
    cau_side_t          side3_reg, side3_next;
    logic signed [32:0] num_re_reg, num_im_reg;
    logic [31:0]        mag_reg;
    logic signed [32:0] mul_re, mul_im;
    logic [16:0]        sat_re, sat_im;

    assign mul_re = (33'(p_rr_reg) - 33'(p_ii_reg)) >>> FRAC_BITS;
    assign mul_im = (33'(p_ri_reg) + 33'(p_ir_reg)) >>> FRAC_BITS;

    always_comb
    begin
        if (cmd2_reg == CMD_MUL)
        begin
            sat_re = sat16(34'(mul_re));
            sat_im = sat16(34'(mul_im));
        end
        else
        begin
            sat_re = sat16(34'(as_re_reg));
            sat_im = sat16(34'(as_im_reg));
        end
        side3_next.cmd = cmd2_reg;
        side3_next.re  = sat_re[15:0];
        side3_next.im  = sat_im[15:0];
        side3_next.ovf = sat_re[16] | sat_im[16];
        side3_next.dz  = (p_bb_reg == '0) && (p_cc_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side3_reg  <= side3_next;
            num_re_reg <= 33'(p_rr_reg) + 33'(p_ii_reg);
            num_im_reg <= 33'(p_ir_reg) - 33'(p_ri_reg);
            mag_reg    <= 32'(p_bb_reg) + 32'(p_cc_reg);
        end
    end

    // Dividers for both quotient parts; the imaginary one carries the side data
    logic        vld_re, vld_im;
    logic [15:0] quo_re, quo_im;
    logic        sat_q_re, sat_q_im;
    cau_side_t   side_unused, side_out;

    cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_re (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v3_reg),
        .num      (num_re_reg),
        .mag      (mag_reg),
        .side_in  (side3_reg),
        .out_vld  (vld_re),
        .quo      (quo_re),
        .sat      (sat_q_re),
        .side_out (side_unused)
    );

    cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_im (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v3_reg),
        .num      (num_im_reg),
        .mag      (mag_reg),
        .side_in  (side3_reg),
        .out_vld  (vld_im),
        .quo      (quo_im),
        .sat      (sat_q_im),
        .side_out (side_out)
    );

    // Result select
    assign out_valid = vld_im;

    always_comb
    begin
        if (side_out.cmd == CMD_DIV)
        begin
            if (side_out.dz)
            begin
                res_real       = '0;
                res_imag       = '0;
                overflow       = 1'b0;
                divide_by_zero = 1'b1;
            end
            else
            begin
                res_real       = quo_re;
                res_imag       = quo_im;
                overflow       = sat_q_re | sat_q_im;
                divide_by_zero = 1'b0;
            end
        end
        else
        begin
            res_real       = side_out.re;
            res_imag       = side_out.im;
            overflow       = side_out.ovf;
            divide_by_zero = 1'b0;
        end
    end

`ifndef ASSERT_OFF
    // Both dividers stay in lockstep
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        vld_re == vld_im)
        else $error("divider valid bits diverged");

    // A zero divisor yields zero parts and no overflow
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && divide_by_zero) |-> (res_real == '0 && res_imag == '0 && !overflow))
        else $error("divide-by-zero result not cleared");

    // Overflow means at least one part sits at a rail
    a_ovf_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow) |->
        (res_real == 16'h7fff || res_real == 16'h8000 ||
         res_imag == 16'h7fff || res_imag == 16'h8000))
        else $error("overflow flagged without a saturated part");
`endif

endmodule

`default_nettype wire
